// ===== hw/rtl/dlr_pkg.sv =====
// Shared definitions for the DDA line rasterizer: default sizes, register
// indexes, reset values and the item action codes. No dependencies.
`default_nettype none

package dlr_pkg;

  localparam int DEFAULT_FRAC_BITS   = 16;
  localparam int DEFAULT_COORD_BITS  = 14;
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  localparam int CFG_W   = 13;
  localparam int IDX_W   = 24;
  localparam int COLOR_W = 32;

  localparam logic [CFG_W-1:0] RESET_SCREEN_WIDTH  = 13'd1280;
  localparam logic [CFG_W-1:0] RESET_SCREEN_HEIGHT = 13'd720;

  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_e;

  typedef enum logic {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== hw/rtl/dlr_fifo.sv =====
// Small register-based FIFO that decouples the rasterizer front and back.
// Standalone; no package needed.
`default_nettype none

module dlr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] pop_data_o,
  output      logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o     = (fill_q == NW'(DEPTH));
  assign empty_o    = (fill_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + NW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dlr_front.sv =====
// Rasterizer front end: accepts words, forwards advances and turns a start into
// a setup command with per-axis restoring dividers. Depends on dlr_pkg.
`default_nettype none

module dlr_front #(
  parameter int FRAC_BITS  = 16,
  parameter int COORD_BITS = 14,
  parameter int ENTRY_W    = 128
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic                         action_i,
  input  wire logic signed [COORD_BITS-1:0] x_start_i,
  input  wire logic signed [COORD_BITS-1:0] y_start_i,
  input  wire logic signed [COORD_BITS-1:0] x_end_i,
  input  wire logic signed [COORD_BITS-1:0] y_end_i,
  input  wire logic [dlr_pkg::COLOR_W-1:0]  line_color_i,
  output      logic                         push_o,
  output      logic [ENTRY_W-1:0]           push_data_o,
  input  wire logic                         full_i
);

  import dlr_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int SW    = FRAC_BITS + 2;
  localparam int QW    = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  typedef enum logic [3:0] {
    FE_IDLE = 4'b0001,
    FE_LEN  = 4'b0010,
    FE_DIV  = 4'b0100,
    FE_PUSH = 4'b1000
  } fe_state_e;

  fe_state_e state_q, state_d;

  logic                accept;
  logic signed [CW:0]  dx, dy;
  logic [CW:0]         abs_x, abs_y;

  // Operand and divider registers.
  logic                neg_x_q, neg_y_q;
  logic [CW-1:0]       mag_x_q, mag_y_q;
  logic [CW-1:0]       len_q, len_d;
  logic [CW:0]         rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic [QW-1:0]       quo_x_q, quo_x_d, quo_y_q, quo_y_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic signed [CW-1:0] x0_q, y0_q;
  logic [COLOR_W-1:0]  color_q;

  logic [CW:0]         try_x, try_y;
  logic                ge_x, ge_y;
  logic                up_x, up_y;
  logic [SW-1:0]       smag_x, smag_y;
  logic signed [SW-1:0] step_x, step_y;
  logic [CW:0]         count;
  logic [ENTRY_W-1:0]  setup_entry, advance_entry;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != FE_IDLE) || full_i;

  assign dx    = (CW+1)'(x_end_i) - (CW+1)'(x_start_i);
  assign dy    = (CW+1)'(y_end_i) - (CW+1)'(y_start_i);
  assign abs_x = dx[CW] ? -dx : dx;
  assign abs_y = dy[CW] ? -dy : dy;

  // One quotient bit per cycle; the first pass takes the integer bit.
  assign try_x = (cnt_q == '0) ? rem_x_q : {rem_x_q[CW-1:0], 1'b0};
  assign try_y = (cnt_q == '0) ? rem_y_q : {rem_y_q[CW-1:0], 1'b0};
  assign ge_x  = try_x >= {1'b0, len_q};
  assign ge_y  = try_y >= {1'b0, len_q};

  // Round half away from zero: bump when twice the remainder reaches the divisor.
  assign up_x   = {rem_x_q, 1'b0} >= {2'b00, len_q};
  assign up_y   = {rem_y_q, 1'b0} >= {2'b00, len_q};
  assign smag_x = SW'(quo_x_q) + SW'(up_x);
  assign smag_y = SW'(quo_y_q) + SW'(up_y);

  always_comb begin
    step_x = '0;
    step_y = '0;
    if (len_q != '0) begin
      step_x = neg_x_q ? -$signed(smag_x) : $signed(smag_x);
      step_y = neg_y_q ? -$signed(smag_y) : $signed(smag_y);
    end
  end

  assign count         = (CW+1)'(len_q) + (CW+1)'(1);
  assign setup_entry   = {ACT_START, color_q, y0_q, x0_q, count, step_y, step_x};
  assign advance_entry = {ACT_ADVANCE, {(ENTRY_W-1){1'b0}}};

  assign push_o      = (state_q == FE_IDLE && accept && action_i == ACT_ADVANCE) ||
                       (state_q == FE_PUSH && !full_i);
  assign push_data_o = (state_q == FE_PUSH) ? setup_entry : advance_entry;

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    rem_x_d = rem_x_q;
    rem_y_d = rem_y_q;
    quo_x_d = quo_x_q;
    quo_y_d = quo_y_q;
    cnt_d   = cnt_q;
    case (state_q)
      FE_IDLE: begin
        if (accept && action_i == ACT_START) begin
          state_d = FE_LEN;
        end
      end
      FE_LEN: begin
        len_d   = (mag_x_q > mag_y_q) ? mag_x_q : mag_y_q;
        rem_x_d = {1'b0, mag_x_q};
        rem_y_d = {1'b0, mag_y_q};
        quo_x_d = '0;
        quo_y_d = '0;
        cnt_d   = '0;
        state_d = FE_DIV;
      end
      FE_DIV: begin
        rem_x_d = ge_x ? try_x - {1'b0, len_q} : try_x;
        rem_y_d = ge_y ? try_y - {1'b0, len_q} : try_y;
        quo_x_d = {quo_x_q[QW-2:0], ge_x};
        quo_y_d = {quo_y_q[QW-2:0], ge_y};
        cnt_d   = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(FRAC_BITS)) begin
          state_d = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (!full_i) begin
          state_d = FE_IDLE;
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    rem_x_q <= rem_x_d;
    rem_y_q <= rem_y_d;
    quo_x_q <= quo_x_d;
    quo_y_q <= quo_y_d;
    if (state_q == FE_IDLE && accept && action_i == ACT_START) begin
      neg_x_q <= dx[CW];
      neg_y_q <= dy[CW];
      mag_x_q <= abs_x[CW-1:0];
      mag_y_q <= abs_y[CW-1:0];
      x0_q    <= x_start_i;
      y0_q    <= y_start_i;
      color_q <= line_color_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dlr_back.sv =====
// Rasterizer back end: holds the line walk state, runs setup and advance
// commands and emits pixels through a two-stage pipeline. Depends on dlr_pkg.
`default_nettype none

module dlr_back #(
  parameter int FRAC_BITS  = 16,
  parameter int COORD_BITS = 14,
  parameter int ENTRY_W    = 128
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [ENTRY_W-1:0]           cmd_i,
  input  wire logic                         empty_i,
  output      logic                         pop_o,
  input  wire logic [dlr_pkg::CFG_W-1:0]    screen_width_i,
  input  wire logic [dlr_pkg::CFG_W-1:0]    screen_height_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic signed [COORD_BITS-1:0] pixel_x_o,
  output      logic signed [COORD_BITS-1:0] pixel_y_o,
  output      logic [dlr_pkg::IDX_W-1:0]    pixel_addr_o,
  output      logic [dlr_pkg::COLOR_W-1:0]  pixel_color_o,
  output      logic                         write_enable_o,
  output      logic                         last_pixel_o
);

  import dlr_pkg::*;

  localparam int CW     = COORD_BITS;
  localparam int SW     = FRAC_BITS + 2;
  localparam int PW     = COORD_BITS + FRAC_BITS + 2;
  localparam int RW     = COORD_BITS + 2;
  localparam int CMP_W  = (RW > CFG_W + 1) ? RW : CFG_W + 1;
  localparam int PROD_W = 2 * CFG_W;
  localparam int O_SY   = SW;
  localparam int O_CNT  = 2 * SW;
  localparam int O_X0   = 2 * SW + CW + 1;
  localparam int O_Y0   = O_X0 + CW;
  localparam int O_COL  = O_Y0 + CW;
  localparam int O_KIND = O_COL + COLOR_W;

  logic                  cmd_kind;
  logic signed [SW-1:0]  cmd_step_x, cmd_step_y;
  logic [CW:0]           cmd_count;
  logic signed [CW-1:0]  cmd_x0, cmd_y0;
  logic [COLOR_W-1:0]    cmd_color;

  // Walk state.
  logic                  active_q;
  logic signed [PW-1:0]  pos_x_q, pos_y_q;
  logic signed [SW-1:0]  step_x_q, step_y_q;
  logic [CW:0]           left_q;
  logic [COLOR_W-1:0]    color_q;

  // Rounding stage.
  logic                  va_q;
  logic signed [RW-1:0]  rx_a_q, ry_a_q;
  logic                  last_a_q;
  logic [COLOR_W-1:0]    col_a_q;

  logic                  move_b, emit;
  logic signed [PW-1:0]  half_c, sum_x, sum_y;
  logic                  vis;
  logic [CMP_W-1:0]      ux, uy;
  logic [CFG_W-1:0]      x13, y13;
  logic [PROD_W-1:0]     prod, lin;

  assign cmd_kind   = cmd_i[O_KIND];
  assign cmd_step_x = cmd_i[SW-1:0];
  assign cmd_step_y = cmd_i[O_SY +: SW];
  assign cmd_count  = cmd_i[O_CNT +: CW+1];
  assign cmd_x0     = cmd_i[O_X0 +: CW];
  assign cmd_y0     = cmd_i[O_Y0 +: CW];
  assign cmd_color  = cmd_i[O_COL +: COLOR_W];

  assign move_b = !out_valid_o || !out_stall_i;
  assign pop_o  = !empty_i && (!va_q || move_b);
  assign emit   = pop_o && cmd_kind == ACT_ADVANCE && active_q;

  // Half away from zero as one add: negative values take half minus one.
  assign half_c = {{(PW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  assign sum_x  = pos_x_q + half_c - PW'({1'b0, pos_x_q[PW-1]});
  assign sum_y  = pos_y_q + half_c - PW'({1'b0, pos_y_q[PW-1]});

  assign ux   = CMP_W'($unsigned(rx_a_q));
  assign uy   = CMP_W'($unsigned(ry_a_q));
  assign vis  = !rx_a_q[RW-1] && !ry_a_q[RW-1] &&
                (ux < CMP_W'(screen_width_i)) && (uy < CMP_W'(screen_height_i));
  assign x13  = CFG_W'(ux);
  assign y13  = CFG_W'(uy);
  assign prod = PROD_W'(y13) * PROD_W'(screen_width_i);
  assign lin  = prod + PROD_W'(x13);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      va_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (pop_o && cmd_kind == ACT_START) begin
        active_q <= 1'b1;
      end else if (emit && left_q == (CW+1)'(1)) begin
        active_q <= 1'b0;
      end
      if (emit) begin
        va_q <= 1'b1;
      end else if (move_b) begin
        va_q <= 1'b0;
      end
      if (move_b) begin
        out_valid_o <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_kind == ACT_START) begin
      pos_x_q  <= PW'(cmd_x0) <<< FRAC_BITS;
      pos_y_q  <= PW'(cmd_y0) <<< FRAC_BITS;
      step_x_q <= cmd_step_x;
      step_y_q <= cmd_step_y;
      left_q   <= cmd_count;
      color_q  <= cmd_color;
    end else if (emit) begin
      pos_x_q  <= pos_x_q + PW'(step_x_q);
      pos_y_q  <= pos_y_q + PW'(step_y_q);
      left_q   <= left_q - (CW+1)'(1);
    end
    if (emit) begin
      rx_a_q   <= sum_x[PW-1:FRAC_BITS];
      ry_a_q   <= sum_y[PW-1:FRAC_BITS];
      last_a_q <= (left_q == (CW+1)'(1));
      col_a_q  <= color_q;
    end
    if (move_b && va_q) begin
      pixel_x_o      <= rx_a_q[CW-1:0];
      pixel_y_o      <= ry_a_q[CW-1:0];
      pixel_addr_o   <= vis ? lin[IDX_W-1:0] : '0;
      pixel_color_o  <= col_a_q;
      write_enable_o <= vis;
      last_pixel_o   <= last_a_q;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dda_line_rasterizer.sv =====
// Top level of the DDA line rasterizer: configuration registers, front end,
// command queue and back end. Depends on dlr_pkg, dlr_front, dlr_fifo, dlr_back.
//
// Usage: the input channel takes one word per accepted handshake. A word with
// action start latches two end points and a color; a word with action advance
// asks for the next pixel of the current line. A line of length L (the larger
// absolute delta) yields L + 1 pixels, the last one flagged by last_pixel_o.
// Advances with no line in progress are dropped and give no output word.
// An accepted advance passes through the command queue, the rounding stage
// and the output register to the output channel. Throughput: advances are
// taken one per cycle while in_stall_o is low. A start keeps the front end
// busy in its length, divide and push states, the restoring divider making one
// quotient bit of both per-step increments per cycle; the next word waits.
// Stalls: the output register holds its word while out_stall_i is high; the
// back end keeps a second pixel in its rounding stage and then stops draining
// the command queue, which fills and in turn raises in_stall_o.
// Reset: asynchronous, active low. It empties the queue and the pipeline,
// ends any line in progress and loads screen width 1280 and height 720.
// Configuration writes are taken whenever cfg_we_i is high and must only
// happen while the block is idle.
`default_nettype none

module dda_line_rasterizer #(
  parameter int FRAC_BITS   = dlr_pkg::DEFAULT_FRAC_BITS,
  parameter int COORD_BITS  = dlr_pkg::DEFAULT_COORD_BITS,
  parameter int QUEUE_DEPTH = dlr_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration write port.
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_index_i,
  input  wire logic [dlr_pkg::CFG_W-1:0]    cfg_wdata_i,
  // Input channel.
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic                         action_i,
  input  wire logic signed [COORD_BITS-1:0] x_start_i,
  input  wire logic signed [COORD_BITS-1:0] y_start_i,
  input  wire logic signed [COORD_BITS-1:0] x_end_i,
  input  wire logic signed [COORD_BITS-1:0] y_end_i,
  input  wire logic [dlr_pkg::COLOR_W-1:0]  line_color_i,
  // Output channel.
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic signed [COORD_BITS-1:0] pixel_x_o,
  output      logic signed [COORD_BITS-1:0] pixel_y_o,
  output      logic [dlr_pkg::IDX_W-1:0]    pixel_addr_o,
  output      logic [dlr_pkg::COLOR_W-1:0]  pixel_color_o,
  output      logic                         write_enable_o,
  output      logic                         last_pixel_o
);

  import dlr_pkg::*;

  // A queue entry carries both increments, the pixel count, the start point,
  // the color and the command kind.
  localparam int ENTRY_W = 2 * (FRAC_BITS + 2) + (COORD_BITS + 1) + 2 * COORD_BITS +
                           COLOR_W + 1;

  logic [CFG_W-1:0]   screen_width_q, screen_height_q;
  logic               push, full, pop, empty;
  logic [ENTRY_W-1:0] push_data, pop_data;

  // Screen registers; the index is a single bit, so both codes are covered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= RESET_SCREEN_WIDTH;
      screen_height_q <= RESET_SCREEN_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata_i;
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dlr_front #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .line_color_i (line_color_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  dlr_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  dlr_back #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (pop_data),
    .empty_i         (empty),
    .pop_o           (pop),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_addr_o    (pixel_addr_o),
    .pixel_color_o   (pixel_color_o),
    .write_enable_o  (write_enable_o),
    .last_pixel_o    (last_pixel_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb_dda_line_rasterizer.sv =====
// Self-checking testbench for dda_line_rasterizer: drives start and advance words with
// random gaps and output stalls; every pixel word is checked against a built-in line
// walker or a typed plan row. Depends on dlr_pkg and the rasterizer RTL only.
`default_nettype none

module tb_dda_line_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  import dlr_pkg::*;

  localparam int FRAC = DEFAULT_FRAC_BITS;
  localparam int CW = DEFAULT_COORD_BITS;
  localparam int COORD_MIN = -(1 << (CW - 1));
  localparam int COORD_MAX = (1 << (CW - 1)) - 1;
  // Cycles to let a start finish its division before the block counts as idle.
  localparam int DRAIN_CYCLES = FRAC + 8;
  localparam int WORDS_PER_PHASE = 215;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [IDX_W-1:0] index;
    logic [COLOR_W-1:0] color;
    logic we;
    logic last;
  } pixel_t;

  // One row of the directed plan. On advance rows the color column doubles as the
  // expected pixel color when the row carries a hand-written expectation.
  typedef struct {
    action_e act;
    int xs, ys, xe, ye;
    logic [COLOR_W-1:0] color;
    bit typed;
    int px, py, idx;
    bit we, last;
  } plan_row_t;

  typedef enum int {RX_FREE, RX_RANDOM, RX_BURSTY} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_reg_e cfg_index_i = CFG_SCREEN_WIDTH;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  action_e action_i = ACT_START;
  logic signed [CW-1:0] x_start_i = '0;
  logic signed [CW-1:0] y_start_i = '0;
  logic signed [CW-1:0] x_end_i = '0;
  logic signed [CW-1:0] y_end_i = '0;
  logic [COLOR_W-1:0] line_color_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [CW-1:0] pixel_x_o;
  logic signed [CW-1:0] pixel_y_o;
  logic [IDX_W-1:0] pixel_addr_o;
  logic [COLOR_W-1:0] pixel_color_o;
  logic write_enable_o;
  logic last_pixel_o;

  dda_line_rasterizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .x_start_i     (x_start_i),
    .y_start_i     (y_start_i),
    .x_end_i       (x_end_i),
    .y_end_i       (y_end_i),
    .line_color_i  (line_color_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_addr_o  (pixel_addr_o),
    .pixel_color_o (pixel_color_o),
    .write_enable_o(write_enable_o),
    .last_pixel_o  (last_pixel_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Line walker state, kept apart from the block. Positions carry FRAC fraction bits.
  logic [CFG_W-1:0] scr_w = RESET_SCREEN_WIDTH;
  logic [CFG_W-1:0] scr_h = RESET_SCREEN_HEIGHT;
  bit line_live = 1'b0;
  longint pen_x = 0, pen_y = 0, inc_x = 0, inc_y = 0;
  int pixels_left = 0;
  logic [COLOR_W-1:0] ink = '0;

  pixel_t expected_pixels[$];
  int mismatches = 0;
  int burst_left = 0;

  // Directed plan, run at the reset screen size of 1280 by 720.
  plan_row_t plan [0:26] = '{
    // Advance before any line exists is dropped.
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0},
    // Zero-length line gives exactly one pixel at the start point, flagged last.
    '{ACT_START, 5, 7, 5, 7, 32'hDEADBEEF, 0, 0, 0, 0, 0, 0},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'hDEADBEEF, 1, 5, 7, 8965, 1, 1},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0},
    // Longest possible diagonal, corner to corner.
    '{ACT_START, -8192, -8192, 8191, 8191, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'hFFFFFFFF, 1, -8192, -8192, 0, 0, 0},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0},
    // A new start abandons the diagonal; zero length at the top corner.
    '{ACT_START, 8191, 8191, 8191, 8191, 32'h0, 0, 0, 0, 0, 0, 0},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'h0, 1, 8191, 8191, 0, 0, 1},
    '{ACT_START, 0, 0, 1279, 719, 32'h12345678, 0, 0, 0, 0, 0, 0},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'h12345678, 1, 0, 0, 0, 1, 0},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0},
    // Last visible pixel of the screen, then a vertical walk.
    '{ACT_START, 1279, 719, 1279, 0, 32'h00FF00FF, 0, 0, 0, 0, 0, 0},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'h00FF00FF, 1, 1279, 719, 921599, 1, 0},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0},
    // Just past the right and bottom edges.
    '{ACT_START, 1280, 720, 1283, 722, 32'hA5A5A5A5, 0, 0, 0, 0, 0, 0},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'hA5A5A5A5, 1, 1280, 720, 0, 0, 0},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0},
    // Half-pixel positions round away from zero, in both directions.
    '{ACT_START, 0, 0, 2, 1, 32'h5A5A5A5A, 0, 0, 0, 0, 0, 0},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'h5A5A5A5A, 1, 0, 0, 0, 1, 0},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0},
    '{ACT_START, 0, 0, -2, -1, 32'h0F0F0F0F, 0, 0, 0, 0, 0, 0},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0},
    '{ACT_ADVANCE, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0}
  };

  // Per-step increment: delta * 2^FRAC / len, rounded half away from zero.
  function automatic longint scaled_step(longint delta, longint len);
    longint m, q;
    m = (delta < 0) ? -delta : delta;
    q = ((m << FRAC) + len / 2) / len;
    return (delta < 0) ? -q : q;
  endfunction

  // Fixed-point position to whole pixels, rounded half away from zero.
  function automatic longint round_fix(longint p);
    longint m, r;
    m = (p < 0) ? -p : p;
    r = (m + (longint'(1) << (FRAC - 1))) >> FRAC;
    return (p < 0) ? -r : r;
  endfunction

  // Applies one accepted word to the walker. Returns 1 with the pixel it yields.
  function automatic bit trace_word(input action_e act, input int xs, ys, xe, ye,
                                    input logic [COLOR_W-1:0] color, output pixel_t px);
    longint dx, dy, ax, ay, len, rx, ry, spot;
    bit vis;
    px = '0;
    if (act == ACT_START) begin
      dx = longint'(xe) - xs;
      dy = longint'(ye) - ys;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      len = (ax > ay) ? ax : ay;
      inc_x = (len == 0) ? 0 : scaled_step(dx, len);
      inc_y = (len == 0) ? 0 : scaled_step(dy, len);
      pen_x = longint'(xs) * (longint'(1) << FRAC);
      pen_y = longint'(ys) * (longint'(1) << FRAC);
      pixels_left = int'(len) + 1;
      ink = color;
      line_live = 1'b1;
      return 1'b0;
    end
    if (!line_live) return 1'b0;
    rx = round_fix(pen_x);
    ry = round_fix(pen_y);
    // Visibility is judged on the full rounded position, before it is cut to CW bits.
    vis = (rx >= 0) && (ry >= 0) && (rx < longint'(scr_w)) && (ry < longint'(scr_h));
    spot = ry * longint'(scr_w) + rx;
    pen_x += inc_x;
    pen_y += inc_y;
    pixels_left--;
    line_live = (pixels_left != 0);
    px.x = rx[CW-1:0];
    px.y = ry[CW-1:0];
    px.index = vis ? spot[IDX_W-1:0] : '0;
    px.color = ink;
    px.we = vis;
    px.last = !line_live;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] ERROR %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s: got %h, want %h", name, got, want));
  endtask

  // Offers one word and returns right after the edge that accepts it. The sender works
  // in bursts; between bursts valid may drop for a random gap.
  task automatic send_word(action_e act, int xs, ys, xe, ye, logic [COLOR_W-1:0] color);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    action_i <= act;
    x_start_i <= CW'(xs);
    y_start_i <= CW'(ys);
    x_end_i <= CW'(xe);
    y_end_i <= CW'(ye);
    line_color_i <= color;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Sends a word and queues the pixel the walker predicts for it.
  task automatic issue_word(action_e act, int xs, ys, xe, ye, logic [COLOR_W-1:0] color,
                            output bit made);
    pixel_t px;
    send_word(act, xs, ys, xe, ye, color);
    made = trace_word(act, xs, ys, xe, ye, color, px);
    if (made) expected_pixels.push_back(px);
  endtask

  // Drops valid, waits for every expected pixel, then lets any division run out.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_screen(cfg_reg_e which, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= which;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (which == CFG_SCREEN_WIDTH) scr_w = value;
    else scr_h = value;
  endtask

  function automatic int clamp_coord(int v);
    return (v < COORD_MIN) ? COORD_MIN : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  function automatic int any_coord();
    logic signed [CW-1:0] r;
    r = CW'($urandom);
    return r;
  endfunction

  // A coordinate around the visible span, a few pixels past both edges.
  function automatic int near_coord(int span);
    return clamp_coord(int'($urandom_range(0, span + 32)) - 16);
  endfunction

  // Receiver: switches now and then between never stalling, stalls drawn at random
  // and long on/off runs, so stalls land on every stage of the pipeline.
  rx_mode_e rx_mode = RX_FREE;
  int rx_mode_left = 0;
  int rx_run_left = 0;
  bit rx_run_high = 1'b0;

  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(20, 200);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_FREE: out_stall_i <= 1'b0;
      RX_RANDOM: out_stall_i <= ($urandom_range(0, 2) == 0);
      default: begin
        if (rx_run_left == 0) begin
          rx_run_left = $urandom_range(1, 12);
          rx_run_high = !rx_run_high;
        end
        rx_run_left--;
        out_stall_i <= rx_run_high;
      end
    endcase
  end

  // Every accepted pixel word is checked against the oldest expectation.
  always @(posedge clk_i) begin : pixel_check
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel word (%0d,%0d) with none expected",
                                  pixel_x_o, pixel_y_o));
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_x", pixel_x_o, want.x);
        check_field("pixel_y", pixel_y_o, want.y);
        check_field("pixel_addr", pixel_addr_o, want.index);
        check_field("pixel_color", pixel_color_o, want.color);
        check_field("write_enable", write_enable_o, want.we);
        check_field("last_pixel", last_pixel_o, want.last);
      end
    end
  end

  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    // Screen sizes per random phase; a negative entry draws a random size. The extremes
    // come first.
    int phase_w [7] = '{8191, 0, 1, 64, 4096, 300, -1};
    int phase_h [7] = '{8191, 0, 1, 48, 1, 8191, -1};
    pixel_t px, typed_px;
    bit made;
    int w, h, sent, kind, reach, xs, ys, xe, ye, walk;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      send_word(plan[i].act, plan[i].xs, plan[i].ys, plan[i].xe, plan[i].ye, plan[i].color);
      made = trace_word(plan[i].act, plan[i].xs, plan[i].ys, plan[i].xe, plan[i].ye,
                        plan[i].color, px);
      if (made && plan[i].typed) begin
        typed_px.x = CW'(plan[i].px);
        typed_px.y = CW'(plan[i].py);
        typed_px.index = IDX_W'(plan[i].idx);
        typed_px.color = plan[i].color;
        typed_px.we = plan[i].we;
        typed_px.last = plan[i].last;
        expected_pixels.push_back(typed_px);
      end else if (made) begin
        expected_pixels.push_back(px);
      end
    end

    foreach (phase_w[p]) begin
      settle();
      w = (phase_w[p] < 0) ? $urandom_range(1, 8191) : phase_w[p];
      h = (phase_h[p] < 0) ? $urandom_range(1, 8191) : phase_h[p];
      write_screen(CFG_SCREEN_WIDTH, CFG_W'(w));
      write_screen(CFG_SCREEN_HEIGHT, CFG_W'(h));
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        kind = $urandom_range(0, 99);
        xs = near_coord(w);
        ys = near_coord(h);
        if (kind < 85) begin
          // Mostly short lines, a few medium ones, all walked to their last pixel.
          reach = (kind < 5) ? 0 : (kind < 77) ? $urandom_range(1, 31) : $urandom_range(32, 300);
          xe = clamp_coord(xs + int'($urandom_range(0, 2 * reach)) - reach);
          ye = clamp_coord(ys + int'($urandom_range(0, 2 * reach)) - reach);
          issue_word(ACT_START, xs, ys, xe, ye, $urandom, made);
          sent++;
          while (line_live) begin
            issue_word(ACT_ADVANCE, any_coord(), any_coord(), any_coord(), any_coord(),
                       $urandom, made);
            sent++;
          end
          // Advances past the end of a line are dropped by the block.
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2))
              issue_word(ACT_ADVANCE, 0, 0, 0, 0, $urandom, made);
          end
        end else begin
          // Far end points anywhere in the coordinate range; the walk is cut short
          // and the next start abandons it.
          issue_word(ACT_START, any_coord(), any_coord(), any_coord(), any_coord(),
                     $urandom, made);
          sent++;
          walk = $urandom_range(0, 40);
          for (int k = 0; k < walk && line_live; k++) begin
            issue_word(ACT_ADVANCE, any_coord(), any_coord(), any_coord(), any_coord(),
                       $urandom, made);
            sent++;
          end
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/dlr_pkg.sv
hw/rtl/dlr_fifo.sv
hw/rtl/dlr_front.sv
hw/rtl/dlr_back.sv
hw/rtl/dda_line_rasterizer.sv
dv/tb_dda_line_rasterizer.sv
